>>> hw/rtl/hangul_syllable_composer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Hangul syllable composer
// Clocked checks on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HANGUL_SYLLABLE_COMPOSER_ASSERT_SVH
`define HANGUL_SYLLABLE_COMPOSER_ASSERT_SVH

// Check a property on every rising edge of clk outside reset
`define HSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define HSC_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Word types, codes and jamo tables of the Hangul syllable composer.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Opcodes of the input word
  localparam logic [1:0] OP_JAMO   = 2'd0;
  localparam logic [1:0] OP_BACK   = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic [4:0]  NONE_IDX  = 5'd31;
  localparam logic [4:0]  NO_FINAL  = 5'd0;
  localparam logic [4:0]  INIT_CNT  = 5'd19;
  localparam logic [4:0]  MED_CNT   = 5'd21;
  localparam logic [15:0] SYL_BASE  = 16'hAC00;
  localparam logic [15:0] MED_MUL   = 16'd21;
  localparam logic [15:0] FIN_MUL   = 16'd28;
  localparam logic [13:0] VOWEL_LO  = 14'h314F;
  localparam logic [13:0] VOWEL_HI  = 14'h3163;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] plain_jamo;
    logic [13:0] shifted_jamo;
    logic        shift_held;
  } hsc_in_t;

  typedef struct packed {
    logic        erase_previous;
    logic        char_valid;
    logic [15:0] char_code;
    logic        last_of_run;
  } hsc_out_t;

  // One redraw: emit says a result word is produced
  typedef struct packed {
    logic     emit;
    hsc_out_t word;
  } hsc_rd_t;

  // Split of a final when a vowel follows it
  typedef struct packed {
    logic [4:0] keep;
    logic [4:0] moved;
  } hsc_split_t;

  function automatic logic [4:0] init_of(input logic [13:0] c);
    logic [4:0] r;
    unique case (c)
      14'h3131: r = 5'd0;
      14'h3132: r = 5'd1;
      14'h3134: r = 5'd2;
      14'h3137: r = 5'd3;
      14'h3138: r = 5'd4;
      14'h3139: r = 5'd5;
      14'h3141: r = 5'd6;
      14'h3142: r = 5'd7;
      14'h3143: r = 5'd8;
      14'h3145: r = 5'd9;
      14'h3146: r = 5'd10;
      14'h3147: r = 5'd11;
      14'h3148: r = 5'd12;
      14'h3149: r = 5'd13;
      14'h314A: r = 5'd14;
      14'h314B: r = 5'd15;
      14'h314C: r = 5'd16;
      14'h314D: r = 5'd17;
      14'h314E: r = 5'd18;
      default:  r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [13:0] init_code(input logic [4:0] i);
    logic [13:0] r;
    unique case (i)
      5'd0:    r = 14'h3131;
      5'd1:    r = 14'h3132;
      5'd2:    r = 14'h3134;
      5'd3:    r = 14'h3137;
      5'd4:    r = 14'h3138;
      5'd5:    r = 14'h3139;
      5'd6:    r = 14'h3141;
      5'd7:    r = 14'h3142;
      5'd8:    r = 14'h3143;
      5'd9:    r = 14'h3145;
      5'd10:   r = 14'h3146;
      5'd11:   r = 14'h3147;
      5'd12:   r = 14'h3148;
      5'd13:   r = 14'h3149;
      5'd14:   r = 14'h314A;
      5'd15:   r = 14'h314B;
      5'd16:   r = 14'h314C;
      5'd17:   r = 14'h314D;
      5'd18:   r = 14'h314E;
      default: r = 14'h0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] fin_of(input logic [13:0] c);
    logic [4:0] r;
    unique case (c)
      14'h3131: r = 5'd1;
      14'h3132: r = 5'd2;
      14'h3133: r = 5'd3;
      14'h3134: r = 5'd4;
      14'h3135: r = 5'd5;
      14'h3136: r = 5'd6;
      14'h3137: r = 5'd7;
      14'h3139: r = 5'd8;
      14'h313A: r = 5'd9;
      14'h313B: r = 5'd10;
      14'h313C: r = 5'd11;
      14'h313D: r = 5'd12;
      14'h313E: r = 5'd13;
      14'h313F: r = 5'd14;
      14'h3140: r = 5'd15;
      14'h3141: r = 5'd16;
      14'h3142: r = 5'd17;
      14'h3144: r = 5'd18;
      14'h3145: r = 5'd19;
      14'h3146: r = 5'd20;
      14'h3147: r = 5'd21;
      14'h3148: r = 5'd22;
      14'h314A: r = 5'd23;
      14'h314B: r = 5'd24;
      14'h314C: r = 5'd25;
      14'h314D: r = 5'd26;
      14'h314E: r = 5'd27;
      default:  r = NO_FINAL;
    endcase
    return r;
  endfunction

  // Split a final: compound keeps its first half, simple one moves whole
  function automatic hsc_split_t fin_split(input logic [4:0] f);
    hsc_split_t s;
    s.keep = NO_FINAL;
    unique case (f)
      5'd3:    begin s.keep = 5'd1;  s.moved = 5'd9;  end
      5'd5:    begin s.keep = 5'd4;  s.moved = 5'd12; end
      5'd6:    begin s.keep = 5'd4;  s.moved = 5'd18; end
      5'd9:    begin s.keep = 5'd8;  s.moved = 5'd0;  end
      5'd10:   begin s.keep = 5'd8;  s.moved = 5'd6;  end
      5'd11:   begin s.keep = 5'd8;  s.moved = 5'd7;  end
      5'd12:   begin s.keep = 5'd8;  s.moved = 5'd9;  end
      5'd13:   begin s.keep = 5'd8;  s.moved = 5'd16; end
      5'd14:   begin s.keep = 5'd8;  s.moved = 5'd17; end
      5'd15:   begin s.keep = 5'd8;  s.moved = 5'd18; end
      5'd18:   begin s.keep = 5'd17; s.moved = 5'd9;  end
      5'd1:    s.moved = 5'd0;
      5'd2:    s.moved = 5'd1;
      5'd4:    s.moved = 5'd2;
      5'd7:    s.moved = 5'd3;
      5'd8:    s.moved = 5'd5;
      5'd16:   s.moved = 5'd6;
      5'd17:   s.moved = 5'd7;
      5'd19:   s.moved = 5'd9;
      5'd20:   s.moved = 5'd10;
      5'd21:   s.moved = 5'd11;
      5'd22:   s.moved = 5'd12;
      5'd23:   s.moved = 5'd14;
      5'd24:   s.moved = 5'd15;
      5'd25:   s.moved = 5'd16;
      5'd26:   s.moved = 5'd17;
      5'd27:   s.moved = 5'd18;
      default: s.moved = NONE_IDX;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] fin_join(input logic [4:0] a, input logic [4:0] b);
    logic [4:0] r;
    unique case ({a, b})
      {5'd1, 5'd19}:  r = 5'd3;
      {5'd4, 5'd22}:  r = 5'd5;
      {5'd4, 5'd27}:  r = 5'd6;
      {5'd8, 5'd1}:   r = 5'd9;
      {5'd8, 5'd16}:  r = 5'd10;
      {5'd8, 5'd17}:  r = 5'd11;
      {5'd8, 5'd19}:  r = 5'd12;
      {5'd8, 5'd25}:  r = 5'd13;
      {5'd8, 5'd26}:  r = 5'd14;
      {5'd8, 5'd27}:  r = 5'd15;
      {5'd17, 5'd19}: r = 5'd18;
      default:        r = NO_FINAL;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] med_join(input logic [4:0] a, input logic [4:0] b);
    logic [4:0] r;
    unique case ({a, b})
      {5'd8, 5'd0}:   r = 5'd9;
      {5'd8, 5'd1}:   r = 5'd10;
      {5'd8, 5'd20}:  r = 5'd11;
      {5'd13, 5'd4}:  r = 5'd14;
      {5'd13, 5'd5}:  r = 5'd15;
      {5'd13, 5'd20}: r = 5'd16;
      {5'd18, 5'd20}: r = 5'd19;
      default:        r = NONE_IDX;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] med_first(input logic [4:0] v);
    logic [4:0] r;
    unique case (v)
      5'd9, 5'd10, 5'd11:  r = 5'd8;
      5'd14, 5'd15, 5'd16: r = 5'd13;
      5'd19:               r = 5'd18;
      default:             r = NONE_IDX;
    endcase
    return r;
  endfunction

  // Draw the syllable held in ini/med/fin; on says one is on screen now
  function automatic hsc_rd_t redraw(input logic [4:0] ini, input logic [4:0] med,
                                     input logic [4:0] fin, input logic on);
    hsc_rd_t    rd;
    logic       hi;
    logic       hm;
    logic [15:0] idx;
    hi = (ini < INIT_CNT);
    hm = (med < MED_CNT);
    idx = (16'(ini) * MED_MUL + 16'(med)) * FIN_MUL;
    rd.word.erase_previous = on;
    rd.word.last_of_run    = 1'b0;
    rd.word.char_valid     = hi | hm;
    if (hi && hm) begin
      rd.word.char_code = SYL_BASE + idx + 16'(fin);
    end else if (hi) begin
      rd.word.char_code = 16'(init_code(ini));
    end else if (hm) begin
      rd.word.char_code = 16'(VOWEL_LO) + 16'(med);
    end else begin
      rd.word.char_code = 16'h0;
    end
    rd.emit = on | hi | hm;
    return rd;
  endfunction

endpackage

>>> hw/rtl/hangul_syllable_composer.sv
// ----------------------------------------------------------------------------
// hangul_syllable_composer
// Two-set Hangul input automaton: keystroke words in, text edit words out.
// ----------------------------------------------------------------------------
// Each accepted keystroke word is decoded in the cycle it is taken, against
// the held initial, medial and final index, and its one or two edit words go
// into a two-entry result register. A keystroke gives one edit word or none;
// a vowel after a final gives two edit words, drained in turn by the single
// result port from the result register.
// in_ready is high when the result register is empty or its last word is
// being taken in the same cycle.
module hangul_syllable_composer
  import hsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hsc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hsc_out_t out_data
);

`include "hangul_syllable_composer_assert.svh"

  logic [4:0] ini_r, med_r, fin_r;
  logic       on_r;
  logic [4:0] ini_nxt, med_nxt, fin_nxt;
  logic       on_nxt;

  hsc_out_t   slot0_r, slot1_r;
  hsc_out_t   slot0_nxt, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  hsc_rd_t    rd0, rd1;
  logic       accept, pop;
  logic       ini_held, med_held;

  // Handshake: accept only when the result register will be empty
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid & out_ready;
  assign in_ready  = (cnt_r == 2'd0) | ((cnt_r == 2'd1) & out_ready);
  assign accept    = in_valid & in_ready;

  assign ini_held  = (ini_r != NONE_IDX);
  assign med_held  = (med_r != NONE_IDX);

  // Decode one keystroke against the held syllable
  always_comb begin
    logic [13:0] jamo;
    logic [4:0]  ji, ci, jo, cj, cm;
    logic        hi, hm;
    hsc_split_t  sp;
    ini_nxt = ini_r;
    med_nxt = med_r;
    fin_nxt = fin_r;
    on_nxt  = on_r;
    rd0     = '0;
    rd1     = '0;
    jamo    = in_data.shift_held ? in_data.shifted_jamo : in_data.plain_jamo;
    ji      = 5'(jamo - VOWEL_LO);
    ci      = init_of(jamo);
    jo      = fin_of(jamo);
    cj      = fin_join(fin_r, jo);
    cm      = med_join(med_r, ji);
    sp      = fin_split(fin_r);
    hi      = (ini_r != NONE_IDX);
    hm      = (med_r != NONE_IDX);
    unique case (in_data.opcode)
      OP_JAMO: begin
        if ((jamo >= VOWEL_LO) && (jamo <= VOWEL_HI)) begin
          if (fin_r != NO_FINAL) begin
            // Finish the old syllable, carry the final into the new one
            rd0     = redraw(ini_r, med_r, sp.keep, on_r);
            ini_nxt = sp.moved;
            med_nxt = ji;
            fin_nxt = NO_FINAL;
            rd1     = redraw(sp.moved, ji, NO_FINAL, 1'b0);
          end else if (!hm) begin
            med_nxt = ji;
            rd0     = redraw(ini_r, ji, fin_r, on_r);
          end else if (cm != NONE_IDX) begin
            med_nxt = cm;
            rd0     = redraw(ini_r, cm, fin_r, on_r);
          end else begin
            ini_nxt = NONE_IDX;
            med_nxt = ji;
            fin_nxt = NO_FINAL;
            rd0     = redraw(NONE_IDX, ji, NO_FINAL, 1'b0);
          end
        end else begin
          if (hm && (fin_r == NO_FINAL) && hi && (jo != NO_FINAL)) begin
            fin_nxt = jo;
            rd0     = redraw(ini_r, med_r, jo, on_r);
          end else if (hm && (fin_r != NO_FINAL) && (jo != NO_FINAL) &&
                       (cj != NO_FINAL)) begin
            fin_nxt = cj;
            rd0     = redraw(ini_r, med_r, cj, on_r);
          end else begin
            ini_nxt = ci;
            med_nxt = NONE_IDX;
            fin_nxt = NO_FINAL;
            rd0     = redraw(ci, NONE_IDX, NO_FINAL, 1'b0);
          end
        end
        on_nxt = rd1.emit ? rd1.word.char_valid : rd0.word.char_valid;
      end
      OP_BACK: begin
        if (!on_r) begin
          // Nothing of ours on screen: erase only
          rd0.emit                = 1'b1;
          rd0.word.erase_previous = 1'b1;
        end else begin
          if (fin_r != NO_FINAL) begin
            fin_nxt = sp.keep;
          end else if (hm) begin
            med_nxt = med_first(med_r);
          end else if (hi) begin
            ini_nxt = NONE_IDX;
          end
          rd0    = redraw(ini_nxt, med_nxt, fin_nxt, on_r);
          on_nxt = rd0.word.char_valid;
        end
      end
      OP_COMMIT: begin
        ini_nxt = NONE_IDX;
        med_nxt = NONE_IDX;
        fin_nxt = NO_FINAL;
        on_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Pack the edit words and mark the last one
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (rd0.emit) begin
        slot0_nxt = rd0.word;
        slot1_nxt = rd1.word;
        cnt_nxt   = rd1.emit ? 2'd2 : 2'd1;
      end else begin
        slot0_nxt = rd1.word;
        cnt_nxt   = rd1.emit ? 2'd1 : 2'd0;
      end
      if (cnt_nxt == 2'd2) begin
        slot1_nxt.last_of_run = 1'b1;
      end else begin
        slot0_nxt.last_of_run = 1'b1;
      end
    end else if (pop) begin
      // Advance the second word to the head
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  // Hold the syllable state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ini_r <= NONE_IDX;
      med_r <= NONE_IDX;
      fin_r <= NO_FINAL;
      on_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (accept) begin
        ini_r <= ini_nxt;
        med_r <= med_nxt;
        fin_r <= fin_nxt;
        on_r  <= on_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // Checks on the syllable state and the result register
  `HSC_ASSERT(a_one_left_is_last, (cnt_r == 2'd1) |-> slot0_r.last_of_run, "single word not last")
  `HSC_ASSERT(a_first_of_two, (cnt_r == 2'd2) |-> !slot0_r.last_of_run, "first of two marked last")
  `HSC_ASSERT(a_on_screen_held, on_r |-> ini_held || med_held, "on screen but empty")
  `HSC_ASSERT(a_final_needs_syl, (fin_r != NO_FINAL) |-> ini_held && med_held, "stray final")
  `HSC_ASSERT_NEXT(a_pair_drains, (cnt_r == 2'd2) && out_ready, cnt_r == 2'd1, "pair not drained")

endmodule
